>>> hdl/dma7_pkg.sv
package dma7_pkg;

  localparam int unsigned NUM_CH = 7;
  localparam int unsigned CH_W   = 3;

  localparam logic [31:0] PRIO_RESET    = 32'h0765_4321;
  localparam logic [31:0] PRIO_FORCE    = 32'h0800_0800;  // channels 2 and 6 always enabled
  localparam logic [31:0] IRQ_FLAG_MASK = 32'h7F00_0000;
  localparam logic [31:0] IRQ_WR_MASK   = 32'h00FF_803F;
  localparam logic [23:0] BASE_MASK     = 24'hFF_FFFF;

  localparam logic [6:0] OFF_PRIO = 7'h70;
  localparam logic [6:0] OFF_IRQ  = 7'h74;

  localparam logic [3:0] SUB_BASE  = 4'h0;
  localparam logic [3:0] SUB_BLOCK = 4'h4;
  localparam logic [3:0] SUB_CTRL  = 4'h8;

  localparam int unsigned CTRL_START_BIT = 24;
  localparam int unsigned CTRL_TRIG_BIT  = 28;
  localparam logic [CH_W-1:0] CH_CDROM   = 3'd3;

  typedef enum logic [1:0] {
    FN_READ  = 2'd0,
    FN_WRITE = 2'd1,
    FN_POLL  = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  reg_offset;
    logic [31:0] write_data;
    logic        sector_ready;
  } req_t;

  typedef struct packed {
    logic [31:0]     read_data;
    logic            started;
    logic [CH_W-1:0] start_channel;
    logic [1:0]      start_sync;
    logic            start_from_ram;
    logic            start_step_down;
    logic [23:0]     start_base;
    logic [31:0]     start_block;
    logic            irq;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic do_write;
    logic emit_read;
    logic emit_plain;
    logic emit_start;
    logic from_pend;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  ctrl_wr;
    logic  any_start;
    logic  more;
    logic  out_free;
  } stat_t;

endpackage

>>> hdl/dma7_if.sv
interface dma7_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [6:0]  reg_offset;
  logic [31:0] write_data;
  logic        sector_ready;

  modport source (output valid, func, reg_offset, write_data, sector_ready, input ready);
  modport sink   (input valid, func, reg_offset, write_data, sector_ready, output ready);
endinterface

interface dma7_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        started;
  logic [2:0]  start_channel;
  logic [1:0]  start_sync;
  logic        start_from_ram;
  logic        start_step_down;
  logic [23:0] start_base;
  logic [31:0] start_block;
  logic        irq;
  logic        last;

  modport source (output valid, read_data, started, start_channel, start_sync,
                  start_from_ram, start_step_down, start_base, start_block, irq, last,
                  input ready);
  modport sink   (input valid, read_data, started, start_channel, start_sync,
                  start_from_ram, start_step_down, start_base, start_block, irq, last,
                  output ready);
endinterface

>>> hdl/dma7_ctrl.sv
module dma7_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  dma7_pkg::stat_t stat_i,
  output dma7_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_PEND = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.func)
          dma7_pkg::FN_READ: begin
            if (stat_i.out_free) begin
              cmd_o.emit_read = 1'b1;
              state_d         = S_IDLE;
            end
          end
          dma7_pkg::FN_WRITE: begin
            if (stat_i.ctrl_wr) begin
              // control write: check that channel on the next cycle
              cmd_o.do_write = 1'b1;
              state_d        = S_PEND;
            end else if (stat_i.out_free) begin
              cmd_o.do_write   = 1'b1;
              cmd_o.emit_plain = 1'b1;
              state_d          = S_IDLE;
            end
          end
          dma7_pkg::FN_POLL: begin
            state_d = S_PEND;
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.emit_plain = 1'b1;
              state_d          = S_IDLE;
            end
          end
        endcase
      end
      S_PEND: begin
        if (stat_i.out_free) begin
          if (stat_i.any_start) begin
            cmd_o.emit_start = 1'b1;
            state_d          = stat_i.more ? S_SCAN : S_IDLE;
          end else begin
            cmd_o.emit_plain = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd_o.from_pend = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit_start = 1'b1;
          if (!stat_i.more) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/dma7_dp.sv
module dma7_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dma7_pkg::cmd_t   cmd_i,
  output dma7_pkg::stat_t  stat_o,
  input  dma7_pkg::req_t   req_i,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  output dma7_pkg::rsp_t   rsp_o
);

  localparam int unsigned NCH = dma7_pkg::NUM_CH;
  localparam int unsigned CW  = dma7_pkg::CH_W;

  // latched item
  dma7_pkg::func_e func_q;
  logic [6:0]      off_q;
  logic [31:0]     wdata_q;
  logic            sect_q;

  logic [23:0] base_q  [NCH];
  logic [31:0] block_q [NCH];
  logic [31:0] ctrl_q  [NCH];
  logic [31:0] prio_q, prio_d;
  logic [31:0] irq_q, irq_d;
  logic [NCH-1:0] pend_q;

  dma7_pkg::rsp_t out_q, out_d;
  logic           out_vld_q;

  logic          in_chan, is_prio, is_irq;
  logic [CW-1:0] off_ch, st_ch, rd_ch;
  logic [3:0]    sub;
  logic [NCH-1:0] startable, live_mask, sel_mask, low_bit;
  logic [31:0]   read_val, irq_wr, irq_st, st_ctrl;
  logic          out_free, emit_any;

  function automatic logic [31:0] with_master(input logic [31:0] v);
    logic [31:0] r;
    r     = v;
    r[31] = v[15] | (|(v[22:16] & v[30:24]));
    return r;
  endfunction

  assign is_prio = (off_q == dma7_pkg::OFF_PRIO);
  assign is_irq  = (off_q == dma7_pkg::OFF_IRQ);
  assign in_chan = (off_q < dma7_pkg::OFF_PRIO);
  assign off_ch  = off_q[6:4];
  assign sub     = off_q[3:0];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      startable[ch] = prio_q[ch*4+3] & ctrl_q[ch][dma7_pkg::CTRL_START_BIT] &
                      ((ctrl_q[ch][10:9] != 2'd0) | ctrl_q[ch][dma7_pkg::CTRL_TRIG_BIT]);
      // device-to-RAM on the disc channel waits for a sector
      if (CW'(ch) == dma7_pkg::CH_CDROM && !ctrl_q[ch][0] && !sect_q) begin
        startable[ch] = 1'b0;
      end
    end
  end

  always_comb begin
    live_mask = startable;
    if (func_q != dma7_pkg::FN_POLL) begin
      live_mask = startable & (NCH'(1) << off_ch);
    end
  end

  assign sel_mask = cmd_i.from_pend ? pend_q : live_mask;
  assign low_bit  = sel_mask & (~sel_mask + NCH'(1));

  always_comb begin
    st_ch = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (sel_mask[i]) begin
        st_ch = CW'(i);
      end
    end
  end

  assign rd_ch = cmd_i.emit_start ? st_ch : off_ch;

  always_comb begin
    read_val = '0;
    if (is_prio) begin
      read_val = prio_q;
    end else if (is_irq) begin
      read_val = irq_q;
    end else if (in_chan) begin
      case (sub)
        dma7_pkg::SUB_BASE:  read_val = {8'd0, base_q[rd_ch]};
        dma7_pkg::SUB_BLOCK: read_val = block_q[rd_ch];
        dma7_pkg::SUB_CTRL:  read_val = ctrl_q[rd_ch];
        default:             read_val = '0;
      endcase
    end
  end

  assign irq_wr  = with_master((irq_q & dma7_pkg::IRQ_FLAG_MASK &
                                ~(wdata_q & dma7_pkg::IRQ_FLAG_MASK)) |
                               (wdata_q & dma7_pkg::IRQ_WR_MASK));
  assign irq_st  = with_master(irq_q | (32'd1 << (5'd24 + 5'(st_ch))));
  assign st_ctrl = ctrl_q[rd_ch];

  always_comb begin
    prio_d = prio_q;
    irq_d  = irq_q;
    if (cmd_i.do_write && is_prio) begin
      prio_d = wdata_q | dma7_pkg::PRIO_FORCE;
    end
    if (cmd_i.do_write && is_irq) begin
      irq_d = irq_wr;
    end
    if (cmd_i.emit_start) begin
      irq_d = irq_st;
    end
  end

  assign out_free = !out_vld_q || rsp_ready_i;
  assign emit_any = cmd_i.emit_read | cmd_i.emit_plain | cmd_i.emit_start;

  always_comb begin
    out_d     = '0;
    out_d.irq = irq_d[31];
    if (cmd_i.emit_start) begin
      out_d.started         = 1'b1;
      out_d.start_channel   = st_ch;
      out_d.start_sync      = st_ctrl[10:9];
      out_d.start_from_ram  = st_ctrl[0];
      out_d.start_step_down = st_ctrl[1];
      out_d.start_base      = base_q[rd_ch];
      out_d.start_block     = block_q[rd_ch];
      out_d.last            = !stat_o.more;
    end else begin
      out_d.read_data = cmd_i.emit_read ? read_val : 32'd0;
      out_d.last      = 1'b1;
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.func      = func_q;
    stat_o.ctrl_wr   = (func_q == dma7_pkg::FN_WRITE) && in_chan && (sub == dma7_pkg::SUB_CTRL);
    stat_o.any_start = |sel_mask;
    stat_o.more      = |(sel_mask & ~low_bit);
    stat_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= dma7_pkg::func_e'(req_i.func);
      off_q   <= req_i.reg_offset;
      wdata_q <= req_i.write_data;
      sect_q  <= req_i.sector_ready;
    end
    if (emit_any) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < NCH; ch++) begin
        base_q[ch]  <= '0;
        block_q[ch] <= '0;
        ctrl_q[ch]  <= '0;
      end
      prio_q    <= dma7_pkg::PRIO_RESET;
      irq_q     <= '0;
      pend_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      prio_q <= prio_d;
      irq_q  <= irq_d;
      if (cmd_i.do_write && in_chan) begin
        case (sub)
          dma7_pkg::SUB_BASE:  base_q[off_ch]  <= wdata_q[23:0] & dma7_pkg::BASE_MASK;
          dma7_pkg::SUB_BLOCK: block_q[off_ch] <= wdata_q;
          dma7_pkg::SUB_CTRL:  ctrl_q[off_ch]  <= wdata_q;
          default: ;
        endcase
      end
      if (cmd_i.emit_start) begin
        ctrl_q[rd_ch] <= st_ctrl & ~((32'd1 << dma7_pkg::CTRL_START_BIT) |
                                     (32'd1 << dma7_pkg::CTRL_TRIG_BIT));
        pend_q        <= sel_mask & ~low_bit;
      end
      if (emit_any) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

>>> hdl/seven_channel_dma_register_controller.sv
// Register and trigger side of a seven-channel DMA controller.
// req_i carries bus operations: func 0 reads the register at reg_offset,
// func 1 writes write_data there, func 2 polls all channels for triggers.
// rsp_o returns one result per item, or one per started channel on a poll
// or a control write; last marks the final result of an item.
// A read or plain write is latched from req_i, then executed into the
// output register. A poll or control write passes through an extra state
// that evaluates triggers, then delivers one start per cycle while rsp_o
// is not stalled; the start scan walks the pending channels lowest first.
// A new item is taken only after the last result of the previous one has
// been emitted.
// The result sits in an output register, so the next item is taken while
// it waits; when rsp_o is stalled, execution of the next result holds until
// the output register frees up, and req_i is not ready meanwhile.
// Reset clears all channel registers and the interrupt register and loads
// the priority/enable register with its default channel order.
module seven_channel_dma_register_controller (
  input logic       clk_i,
  input logic       rst_ni,
  dma7_req_if.sink   req_i,
  dma7_rsp_if.source rsp_o
);

  dma7_pkg::cmd_t  cmd;
  dma7_pkg::stat_t stat;
  dma7_pkg::req_t  req;
  dma7_pkg::rsp_t  rsp;
  logic            req_ready;
  logic            rsp_valid;

  assign req.func         = req_i.func;
  assign req.reg_offset   = req_i.reg_offset;
  assign req.write_data   = req_i.write_data;
  assign req.sector_ready = req_i.sector_ready;
  assign req_i.ready      = req_ready;

  dma7_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dma7_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.valid           = rsp_valid;
  assign rsp_o.read_data       = rsp.read_data;
  assign rsp_o.started         = rsp.started;
  assign rsp_o.start_channel   = rsp.start_channel;
  assign rsp_o.start_sync      = rsp.start_sync;
  assign rsp_o.start_from_ram  = rsp.start_from_ram;
  assign rsp_o.start_step_down = rsp.start_step_down;
  assign rsp_o.start_base      = rsp.start_base;
  assign rsp_o.start_block     = rsp.start_block;
  assign rsp_o.irq             = rsp.irq;
  assign rsp_o.last            = rsp.last;

endmodule

>>> hdl/dma7_checker.sv
module dma7_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        started_i,
  input logic [2:0]  start_channel_i,
  input logic [23:0] start_base_i,
  input logic [31:0] start_block_i,
  input logic [31:0] read_data_i,
  input logic        last_i
);

  // one item at a time: no new transfer right after one was taken
  a_req_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("req taken on consecutive cycles");

  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && started_i |-> start_channel_i != 3'd7 && read_data_i == 32'd0)
    else $error("bad start descriptor");

  a_plain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !started_i |-> last_i && start_channel_i == 3'd0 &&
    start_base_i == 24'd0 && start_block_i == 32'd0)
    else $error("plain result carries start fields");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_data_i) &&
    $stable(last_i) && $stable(started_i))
    else $error("stalled result changed");

endmodule

bind seven_channel_dma_register_controller dma7_checker u_dma7_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .started_i       (rsp_o.started),
  .start_channel_i (rsp_o.start_channel),
  .start_base_i    (rsp_o.start_base),
  .start_block_i   (rsp_o.start_block),
  .read_data_i     (rsp_o.read_data),
  .last_i          (rsp_o.last)
);

>>> test/seven_channel_dma_register_controller_test.sv
module seven_channel_dma_register_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned CALM_TAIL   = 40;
  localparam int unsigned RAND_OPS    = 450;

  typedef struct {
    dma7_pkg::req_t req;
    bit             drain;  // hold this op until every awaited result has arrived
  } bus_op_t;

  logic clk_i;
  logic rst_ni;

  dma7_req_if req_if ();
  dma7_rsp_if rsp_if ();

  seven_channel_dma_register_controller u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow copy of the register file
  logic [23:0] dma_base  [dma7_pkg::NUM_CH];
  logic [31:0] dma_block [dma7_pkg::NUM_CH];
  logic [31:0] dma_ctrl  [dma7_pkg::NUM_CH];
  logic [31:0] prio_en;
  logic [31:0] irq_reg;

  bus_op_t        bus_ops [$];
  dma7_pkg::rsp_t awaited_rsp [$];
  dma7_pkg::req_t held_req;
  bus_op_t        staged_op;
  bit             req_fire;

  int unsigned ops_sent;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned planned;

  function automatic void update_master();
    irq_reg[31] = irq_reg[15] | (|(irq_reg[22:16] & irq_reg[30:24]));
  endfunction

  function automatic dma7_pkg::rsp_t plain_result(logic [31:0] rd);
    dma7_pkg::rsp_t res;
    res           = '0;
    res.read_data = rd;
    res.irq       = irq_reg[31];
    res.last      = 1'b1;
    return res;
  endfunction

  function automatic logic [31:0] reg_value(logic [6:0] off);
    logic [2:0] ch;
    logic [3:0] sub;
    ch  = off[6:4];
    sub = off[3:0];
    if (off == dma7_pkg::OFF_PRIO) return prio_en;
    if (off == dma7_pkg::OFF_IRQ) return irq_reg;
    if (off >= dma7_pkg::OFF_PRIO) return 32'h0;
    if (sub == dma7_pkg::SUB_BASE) return {8'h00, dma_base[ch]};
    if (sub == dma7_pkg::SUB_BLOCK) return dma_block[ch];
    if (sub == dma7_pkg::SUB_CTRL) return dma_ctrl[ch];
    return 32'h0;
  endfunction

  function automatic bit try_launch(logic [2:0] ch, logic sector_ready,
                                    output dma7_pkg::rsp_t res);
    logic [31:0] c;
    c   = dma_ctrl[ch];
    res = '0;
    if (!prio_en[4 * ch + 3] || !c[dma7_pkg::CTRL_START_BIT]) return 1'b0;
    // burst mode needs the manual trigger too
    if (c[10:9] == 2'd0 && !c[dma7_pkg::CTRL_TRIG_BIT]) return 1'b0;
    // disc-to-RAM on channel 3 waits for a sector
    if (ch == dma7_pkg::CH_CDROM && !c[0] && !sector_ready) return 1'b0;
    res.started                 = 1'b1;
    res.start_channel           = ch;
    res.start_sync              = c[10:9];
    res.start_from_ram          = c[0];
    res.start_step_down         = c[1];
    res.start_base              = dma_base[ch];
    res.start_block             = dma_block[ch];
    c[dma7_pkg::CTRL_START_BIT] = 1'b0;
    c[dma7_pkg::CTRL_TRIG_BIT]  = 1'b0;
    dma_ctrl[ch]                = c;
    irq_reg[24 + ch]            = 1'b1;
    update_master();
    res.irq  = irq_reg[31];
    res.last = 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_responses(dma7_pkg::req_t op);
    dma7_pkg::rsp_t batch [$];
    dma7_pkg::rsp_t res;
    logic [2:0]     ch;
    logic [3:0]     sub;
    int             i;
    ch  = op.reg_offset[6:4];
    sub = op.reg_offset[3:0];
    case (op.func)
      dma7_pkg::FN_READ: begin
        batch.push_back(plain_result(reg_value(op.reg_offset)));
      end
      dma7_pkg::FN_WRITE: begin
        if (op.reg_offset == dma7_pkg::OFF_PRIO) begin
          prio_en = op.write_data | dma7_pkg::PRIO_FORCE;
        end else if (op.reg_offset == dma7_pkg::OFF_IRQ) begin
          irq_reg = (irq_reg & dma7_pkg::IRQ_FLAG_MASK &
                     ~(op.write_data & dma7_pkg::IRQ_FLAG_MASK))
                    | (op.write_data & dma7_pkg::IRQ_WR_MASK);
          update_master();
        end else if (op.reg_offset < dma7_pkg::OFF_PRIO) begin
          if (sub == dma7_pkg::SUB_BASE) begin
            dma_base[ch] = op.write_data[23:0] & dma7_pkg::BASE_MASK;
          end else if (sub == dma7_pkg::SUB_BLOCK) begin
            dma_block[ch] = op.write_data;
          end else if (sub == dma7_pkg::SUB_CTRL) begin
            dma_ctrl[ch] = op.write_data;
            if (try_launch(ch, op.sector_ready, res)) batch.push_back(res);
          end
        end
      end
      dma7_pkg::FN_POLL: begin
        for (i = 0; i < dma7_pkg::NUM_CH; i++) begin
          if (try_launch(3'(i), op.sector_ready, res)) batch.push_back(res);
        end
      end
      default: ;
    endcase
    if (batch.size() == 0) batch.push_back(plain_result(32'h0));
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) awaited_rsp.push_back(batch[k]);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_response();
    dma7_pkg::rsp_t want;
    if (awaited_rsp.size() == 0) begin
      if (mismatches < 10) $display("result transfer with nothing awaited");
      mismatches++;
    end else begin
      want = awaited_rsp.pop_front();
      check_field("read_data", want.read_data, rsp_if.read_data);
      check_field("started", 32'(want.started), 32'(rsp_if.started));
      check_field("start_channel", 32'(want.start_channel), 32'(rsp_if.start_channel));
      check_field("start_sync", 32'(want.start_sync), 32'(rsp_if.start_sync));
      check_field("start_from_ram", 32'(want.start_from_ram), 32'(rsp_if.start_from_ram));
      check_field("start_step_down", 32'(want.start_step_down),
                  32'(rsp_if.start_step_down));
      check_field("start_base", 32'(want.start_base), 32'(rsp_if.start_base));
      check_field("start_block", want.start_block, rsp_if.start_block);
      check_field("irq", 32'(want.irq), 32'(rsp_if.irq));
      check_field("last", 32'(want.last), 32'(rsp_if.last));
    end
  endtask

  task automatic add_op(dma7_pkg::func_e f, logic [6:0] off, logic [31:0] data, logic sr,
                        bit drain = 1'b0);
    bus_op_t item;
    item.req.func         = f;
    item.req.reg_offset   = off;
    item.req.write_data   = data;
    item.req.sector_ready = sr;
    item.drain            = drain;
    bus_ops.push_back(item);
    planned++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.func         = '0;
    req_if.reg_offset   = '0;
    req_if.write_data   = '0;
    req_if.sector_ready = 1'b0;
    rsp_if.ready        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Bus master: one op per transfer, random gaps outside the calm tail
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.func         <= '0;
      req_if.reg_offset   <= '0;
      req_if.write_data   <= '0;
      req_if.sector_ready <= 1'b0;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) begin
        predict_responses(held_req);
        ops_sent++;
      end
      if (!req_if.valid || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (bus_ops.size() == 0 ||
                     (bus_ops[0].drain && awaited_rsp.size() != 0)) begin
          req_if.valid <= 1'b0;
        end else if (bus_ops.size() >= CALM_TAIL && hold_left == 0 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left     = $urandom_range(0, 12);
          req_if.valid <= 1'b0;
        end else begin
          staged_op           = bus_ops.pop_front();
          held_req            = staged_op.req;
          req_if.valid        <= 1'b1;
          req_if.func         <= held_req.func;
          req_if.reg_offset   <= held_req.reg_offset;
          req_if.write_data   <= held_req.write_data;
          req_if.sector_ready <= held_req.sector_ready;
        end
      end
    end
  end

  // Result sink with random back-pressure and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_response();
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && ops_sent >= 200) begin
        hold_done    = 1'b1;
        hold_left    = 119;
        rsp_if.ready <= 1'b0;
      end else if (bus_ops.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 12);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0]  ch;
    logic [3:0]  sub;
    logic [31:0] c;
    logic [31:0] v;
    int unsigned pick;
    int unsigned drain_marks;

    for (int i = 0; i < dma7_pkg::NUM_CH; i++) begin
      dma_base[i]  = '0;
      dma_block[i] = '0;
      dma_ctrl[i]  = '0;
    end
    prio_en     = dma7_pkg::PRIO_RESET;
    irq_reg     = '0;
    drain_marks = 0;

    // Directed: reset values, forced enables, trigger rules, deferral, odd offsets
    add_op(dma7_pkg::FN_READ, dma7_pkg::OFF_PRIO, 32'h0, 1'b0);
    add_op(dma7_pkg::FN_READ, dma7_pkg::OFF_IRQ, 32'h0, 1'b0);
    add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_PRIO, 32'h0, 1'b0);  // only 2 and 6 stay on
    add_op(dma7_pkg::FN_WRITE, {3'd2, dma7_pkg::SUB_BASE}, 32'hFFFF_FFFF, 1'b1);
    add_op(dma7_pkg::FN_WRITE, {3'd2, dma7_pkg::SUB_BLOCK}, 32'hFFFF_FFFF, 1'b1);
    // burst, no trigger
    add_op(dma7_pkg::FN_WRITE, {3'd2, dma7_pkg::SUB_CTRL}, 32'h0100_0000, 1'b1);
    add_op(dma7_pkg::FN_POLL, 7'h00, 32'h0, 1'b1);
    // burst with trigger
    add_op(dma7_pkg::FN_WRITE, {3'd2, dma7_pkg::SUB_CTRL}, 32'h1100_0003, 1'b1);
    // disabled channels
    add_op(dma7_pkg::FN_WRITE, {3'd0, dma7_pkg::SUB_CTRL}, 32'h0100_0200, 1'b0);
    add_op(dma7_pkg::FN_WRITE, {3'd1, dma7_pkg::SUB_CTRL}, 32'h0100_0400, 1'b0);
    add_op(dma7_pkg::FN_WRITE, {3'd3, dma7_pkg::SUB_CTRL}, 32'h0100_0200, 1'b0);
    // reserved sync, then a triggered burst
    add_op(dma7_pkg::FN_WRITE, {3'd4, dma7_pkg::SUB_CTRL}, 32'h0100_0600, 1'b0);
    add_op(dma7_pkg::FN_WRITE, {3'd5, dma7_pkg::SUB_CTRL}, 32'h1100_0000, 1'b0);
    add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_PRIO, 32'hFFFF_FFFF, 1'b0);
    add_op(dma7_pkg::FN_POLL, 7'h7F, 32'hFFFF_FFFF, 1'b0);  // channel 3 held back
    add_op(dma7_pkg::FN_POLL, 7'h00, 32'h0, 1'b1);
    add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_IRQ, 32'h00FF_803F, 1'b0);
    add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_IRQ, 32'h7F00_0000, 1'b0);
    add_op(dma7_pkg::FN_WRITE, {3'd6, dma7_pkg::SUB_CTRL}, 32'h0100_0600, 1'b1);
    add_op(dma7_pkg::FN_WRITE, {3'd0, 4'hC}, 32'hFFFF_FFFF, 1'b0);
    add_op(dma7_pkg::FN_READ, {3'd0, 4'hC}, 32'h0, 1'b0);
    add_op(dma7_pkg::FN_WRITE, 7'h7C, 32'hFFFF_FFFF, 1'b0);
    add_op(dma7_pkg::FN_READ, 7'h7F, 32'h0, 1'b0);
    add_op(dma7_pkg::FN_NOP, 7'h74, 32'hFFFF_FFFF, 1'b1);
    add_op(dma7_pkg::FN_READ, {3'd2, dma7_pkg::SUB_CTRL}, 32'h0, 1'b0);
    add_op(dma7_pkg::FN_READ, dma7_pkg::OFF_IRQ, 32'h0, 1'b0);

    while (planned < RAND_OPS) begin
      if ((drain_marks == 0 && planned >= 150) || (drain_marks == 1 && planned >= 330)) begin
        add_op(dma7_pkg::FN_READ, dma7_pkg::OFF_IRQ, 32'h0, 1'b0, 1'b1);
        drain_marks++;
      end
      pick = $urandom_range(0, 99);
      ch   = 3'($urandom_range(0, dma7_pkg::NUM_CH - 1));
      if (pick < 40) begin
        // channel setup: optional base and block writes, then a control write that may start it
        if ($urandom_range(0, 1))
          add_op(dma7_pkg::FN_WRITE, {ch, dma7_pkg::SUB_BASE}, $urandom, 1'b0);
        if ($urandom_range(0, 1))
          add_op(dma7_pkg::FN_WRITE, {ch, dma7_pkg::SUB_BLOCK}, $urandom, 1'b0);
        c                           = $urandom;
        c[dma7_pkg::CTRL_START_BIT] = ($urandom_range(0, 4) != 0);
        c[dma7_pkg::CTRL_TRIG_BIT]  = 1'($urandom_range(0, 1));
        add_op(dma7_pkg::FN_WRITE, {ch, dma7_pkg::SUB_CTRL}, c, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0)
          add_op(dma7_pkg::FN_POLL, 7'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 55) begin
        add_op(dma7_pkg::FN_POLL, 7'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 70) begin
        case ($urandom_range(0, 5))
          0: sub = dma7_pkg::SUB_BASE;
          1: sub = dma7_pkg::SUB_BLOCK;
          2: sub = dma7_pkg::SUB_CTRL;
          default: sub = 4'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0)
          add_op(dma7_pkg::FN_READ,
                 $urandom_range(0, 1) ? dma7_pkg::OFF_PRIO : dma7_pkg::OFF_IRQ,
                 $urandom, 1'b0);
        else if ($urandom_range(0, 3) == 0)
          add_op(dma7_pkg::FN_READ, 7'($urandom), $urandom, 1'($urandom_range(0, 1)));
        else
          add_op(dma7_pkg::FN_READ, {ch, sub}, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        v = $urandom;
        if ($urandom_range(0, 2) != 0) v |= 32'h0888_8888;   // every channel enabled
        add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_PRIO, v, 1'b0);
      end else if (pick < 86) begin
        add_op(dma7_pkg::FN_WRITE, dma7_pkg::OFF_IRQ, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        add_op(dma7_pkg::func_e'($urandom_range(0, 3)), 7'($urandom), $urandom,
               1'($urandom_range(0, 1)));
      end
    end

    do @(posedge clk_i);
    while (bus_ops.size() != 0 || req_if.valid || awaited_rsp.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
